// ----- design/e2rm_pkg.sv -----
// shared constants, types and elaboration-time table functions for the euler to matrix core
package e2rm_pkg;

    localparam int ANGLE_BITS      = 18;
    localparam int ENTRY_FRAC_BITS = 15;
    localparam int CORDIC_STAGES   = 16;

    // angles in 1/64 degree
    localparam int FULL_TURN    = 23040;
    localparam int HALF_TURN    = 11520;
    localparam int QUARTER_TURN = 5760;

    localparam logic [63:0] PI_Q32         = 64'd13493037705;
    localparam logic [63:0] QUARTER_PI_Q32 = 64'd3373259426;

    localparam int Q_FRAC  = 30;
    localparam int XW      = 32;
    localparam int ZW      = 36;
    localparam int ENTRY_W = ENTRY_FRAC_BITS + 1;

    localparam int LANE_LAT  = CORDIC_STAGES + 6;
    localparam int MERGE_LAT = 4;

    typedef logic signed [XW-1:0]      q30_t;
    typedef logic signed [ENTRY_W-1:0] entry_t;

    typedef struct packed {
        q30_t sin_v;
        q30_t cos_v;
    } trig_t;

    // shift-subtract divide, elaboration only
    function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] q;
        logic [63:0] r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[62:0], n[b]};
            if (r >= d) begin
                r    = r - d;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bit_v;
        logic [63:0] rem_v;
        res   = '0;
        rem_v = v;
        bit_v = 64'd1 << 62;
        while (bit_v > rem_v)
            bit_v = bit_v >> 2;
        while (bit_v != 0) begin
            if (rem_v >= res + bit_v) begin
                rem_v = rem_v - (res + bit_v);
                res   = (res >> 1) + bit_v;
            end
            else begin
                res = res >> 1;
            end
            bit_v = bit_v >> 2;
        end
        return res;
    endfunction

    // arctangent of 2^-i in Q.32 from the truncated Q.60 series
    function automatic logic [63:0] atan_q32(input int i);
        logic [63:0] s;
        logic [63:0] term;
        int k;
        int m;
        s = '0;
        k = 0;
        if (i == 0)
            return QUARTER_PI_Q32;
        while (i * (2 * k + 1) <= 60) begin
            m    = 60 - i * (2 * k + 1);
            term = udiv64(64'd1 << m, 64'(2 * k + 1));
            if (k[0] == 1'b0)
                s = s + term;
            else
                s = s - term;
            k++;
        end
        return (s + (64'd1 << 27)) >> 28;
    endfunction

    // start x that cancels the cordic gain, Q.30
    function automatic logic [63:0] cordic_x0();
        logic [63:0] p;
        p = 64'd1 << 60;
        for (int i = 0; i < CORDIC_STAGES; i++)
            p = p + (p >> (2 * i));
        return udiv64(64'd1 << 60, isqrt64(p));
    endfunction

    localparam logic [63:0] CORDIC_X0 = cordic_x0();

endpackage

// ----- design/e2rm_lane.sv -----
// one angle lane: turn reduction, fold, radians scaling and pipelined cordic sine/cosine
module e2rm_lane
    import e2rm_pkg::*;
(
    input  logic                         clk,
    input  logic signed [ANGLE_BITS-1:0] angle,
    output trig_t                        trig
);

    localparam longint NTURN  = ((64'd1 << (ANGLE_BITS - 1)) + FULL_TURN - 1) / FULL_TURN;
    localparam int     VW     = ((ANGLE_BITS > 15) ? ANGLE_BITS : 15) + 3;
    localparam int     RS     = $clog2(2 * NTURN + 1);
    localparam int     REM_W  = $clog2(FULL_TURN);
    localparam int     MAG_W  = $clog2(QUARTER_TURN + 1);
    localparam longint QP     = PI_Q32 / HALF_TURN;
    localparam longint RP     = PI_Q32 % HALF_TURN;
    localparam int     P1_W   = MAG_W + $clog2(QP + 1);
    localparam int     XR_W   = MAG_W + $clog2(HALF_TURN) + 1;
    // half turn is 45 * 2^8
    localparam int     DIV_SHIFT = 8;
    localparam int     DIV_ODD   = HALF_TURN >> DIV_SHIFT;
    localparam int     Y_W    = XR_W - DIV_SHIFT;
    localparam int     MK     = Y_W + 1;
    localparam longint RM     = (64'd1 << MK) / DIV_ODD;
    localparam int     T_W    = Y_W + MK;
    localparam int     ZM_W   = P1_W + 1;
    localparam q30_t   X0     = XW'(CORDIC_X0);

    typedef logic signed [ZW-1:0] z_t;

    logic [REM_W-1:0] rem_reg, rem_next;
    logic [MAG_W-1:0] mag_reg, mag_next;
    logic             sgn2_reg, sgn2_next, hneg2_reg, hneg2_next;
    logic [P1_W-1:0]  p1_3_reg, p1_4_reg;
    logic [XR_W-1:0]  xr_reg;
    logic             sgn3_reg, hneg3_reg, sgn4_reg, hneg4_reg;
    logic [Y_W-1:0]   y_reg;
    logic [T_W-1:0]   t_reg;
    z_t               z_reg, z_next;
    logic             hneg5_reg;

    q30_t cx_reg [CORDIC_STAGES];
    q30_t cy_reg [CORDIC_STAGES];
    z_t   cz_reg [CORDIC_STAGES];
    logic ch_reg [CORDIC_STAGES];

    trig_t trig_reg;

    // modulo full turn by binary-weighted subtraction
    always_comb
    begin
        logic [VW-1:0] v;
        v = VW'(angle) + VW'(NTURN * FULL_TURN);
        for (int k = RS - 1; k >= 0; k--) begin
            if (v >= (VW'(FULL_TURN) << k))
                v = v - (VW'(FULL_TURN) << k);
        end
        rem_next = REM_W'(v);
    end

    // fold into [-90, +90] degrees
    always_comb
    begin
        logic signed [REM_W:0] fa;
        fa         = signed'({1'b0, rem_reg});
        hneg2_next = 1'b0;
        priority if (rem_reg > REM_W'(3 * QUARTER_TURN)) begin
            fa = fa - (REM_W+1)'(FULL_TURN);
        end
        else if (rem_reg > REM_W'(QUARTER_TURN)) begin
            fa         = fa - (REM_W+1)'(HALF_TURN);
            hneg2_next = 1'b1;
        end
        else begin
            fa = fa;
        end
        sgn2_next = fa[REM_W];
        mag_next  = sgn2_next ? MAG_W'(-fa) : MAG_W'(fa);
    end

    // z = round(mag * pi / 180 deg), split as mag*QP + (mag*RP + half)/11520
    always_comb
    begin
        logic [Y_W-1:0]  q0;
        logic [Y_W-1:0]  r;
        logic [ZM_W-1:0] zmag;
        q0     = Y_W'(t_reg >> MK);
        r      = y_reg - Y_W'(q0 * Y_W'(DIV_ODD));
        zmag   = ZM_W'(p1_4_reg) + ZM_W'(q0) + ZM_W'(r >= Y_W'(DIV_ODD));
        z_next = sgn4_reg ? -signed'(ZW'(zmag)) : signed'(ZW'(zmag));
    end

    always_ff @(posedge clk)
    begin
        rem_reg   <= rem_next;
        mag_reg   <= mag_next;
        sgn2_reg  <= sgn2_next;
        hneg2_reg <= hneg2_next;
        p1_3_reg  <= P1_W'(mag_reg) * P1_W'(QP);
        xr_reg    <= XR_W'(mag_reg) * XR_W'(RP) + XR_W'(HALF_TURN / 2);
        sgn3_reg  <= sgn2_reg;
        hneg3_reg <= hneg2_reg;
        p1_4_reg  <= p1_3_reg;
        y_reg     <= Y_W'(xr_reg >> DIV_SHIFT);
        t_reg     <= T_W'(Y_W'(xr_reg >> DIV_SHIFT)) * T_W'(RM);
        sgn4_reg  <= sgn3_reg;
        hneg4_reg <= hneg3_reg;
        z_reg     <= z_next;
        hneg5_reg <= hneg4_reg;
    end

    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
        localparam z_t ATAN = ZW'(atan_q32(i));
        q30_t px, py;
        z_t   pz;
        logic ph;
        if (i == 0) begin : g_first
            assign px = X0;
            assign py = '0;
            assign pz = z_reg;
            assign ph = hneg5_reg;
        end
        else begin : g_next
            assign px = cx_reg[i-1];
            assign py = cy_reg[i-1];
            assign pz = cz_reg[i-1];
            assign ph = ch_reg[i-1];
        end
        always_ff @(posedge clk)
        begin
            if (pz >= 0) begin
                cx_reg[i] <= px - (py >>> i);
                cy_reg[i] <= py + (px >>> i);
                cz_reg[i] <= pz - ATAN;
            end
            else begin
                cx_reg[i] <= px + (py >>> i);
                cy_reg[i] <= py - (px >>> i);
                cz_reg[i] <= pz + ATAN;
            end
            ch_reg[i] <= ph;
        end
    end

    // half-turn fold negates both
    always_ff @(posedge clk)
    begin
        if (ch_reg[CORDIC_STAGES-1]) begin
            trig_reg.sin_v <= -cy_reg[CORDIC_STAGES-1];
            trig_reg.cos_v <= -cx_reg[CORDIC_STAGES-1];
        end
        else begin
            trig_reg.sin_v <= cy_reg[CORDIC_STAGES-1];
            trig_reg.cos_v <= cx_reg[CORDIC_STAGES-1];
        end
    end

    assign trig = trig_reg;

endmodule

// ----- design/e2rm_merge.sv -----
// merge stage: products of the three lanes, matrix sums, transpose and q1.15 rounding
module e2rm_merge
    import e2rm_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    input  logic   in_action,
    input  trig_t  head,
    input  trig_t  pitch,
    input  trig_t  bank,
    output logic   done,
    output entry_t entry [9]
);

    localparam int MW = XW + 2;
    localparam int SH = Q_FRAC - ENTRY_FRAC_BITS;

    typedef logic signed [MW-1:0] m_t;

    localparam logic signed [2*XW-1:0] RND30 = (2*XW)'(64'sd1 <<< (Q_FRAC - 1));
    localparam m_t RND_E = (SH > 0) ? m_t'(64'sd1 <<< ((SH > 0) ? SH - 1 : 0)) : '0;
    localparam m_t HI    = m_t'((64'sd1 <<< ENTRY_FRAC_BITS) - 1);
    localparam m_t LO    = m_t'(-(64'sd1 <<< ENTRY_FRAC_BITS));

    function automatic q30_t mul30(input q30_t a, input q30_t b);
        logic signed [2*XW-1:0] p;
        p = (2*XW)'(a) * (2*XW)'(b) + RND30;
        return XW'(p >>> Q_FRAC);
    endfunction

    function automatic entry_t to_entry(input m_t v);
        m_t t;
        t = (v + RND_E) >>> SH;
        if (t > HI)
            t = HI;
        if (t < LO)
            t = LO;
        return ENTRY_W'(t);
    endfunction

    logic [MERGE_LAT-1:0] vld_reg;
    logic [MERGE_LAT-2:0] act_reg;

    q30_t chcb_reg, shsp_reg, chsb_reg, shcp_reg, sbcp_reg;
    q30_t cbcp_reg, shcb_reg, chsp_reg, sbsh_reg, chcp_reg, sp1_reg;

    q30_t shspsb_reg, shspcb_reg, chspsb_reg, chspcb_reg;
    q30_t chcb2_reg, chsb2_reg, shcp2_reg, sbcp2_reg;
    q30_t cbcp2_reg, shcb2_reg, sbsh2_reg, chcp2_reg, sp2_reg;

    // bank terms registered to line up with the pair products
    q30_t bsin_reg, bcos_reg;

    m_t     m_reg     [9];
    entry_t entry_reg [9];
    entry_t entry_next [9];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[MERGE_LAT-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        bsin_reg <= bank.sin_v;
        bcos_reg <= bank.cos_v;
    end

    always_ff @(posedge clk)
    begin
        act_reg <= {act_reg[MERGE_LAT-3:0], in_action};

        chcb_reg <= mul30(head.cos_v, bank.cos_v);
        shsp_reg <= mul30(head.sin_v, pitch.sin_v);
        chsb_reg <= mul30(head.cos_v, bank.sin_v);
        shcp_reg <= mul30(head.sin_v, pitch.cos_v);
        sbcp_reg <= mul30(bank.sin_v, pitch.cos_v);
        cbcp_reg <= mul30(bank.cos_v, pitch.cos_v);
        shcb_reg <= mul30(head.sin_v, bank.cos_v);
        chsp_reg <= mul30(head.cos_v, pitch.sin_v);
        sbsh_reg <= mul30(bank.sin_v, head.sin_v);
        chcp_reg <= mul30(head.cos_v, pitch.cos_v);
        sp1_reg  <= pitch.sin_v;

        // triple products, left to right
        shspsb_reg <= mul30(shsp_reg, bsin_reg);
        shspcb_reg <= mul30(shsp_reg, bcos_reg);
        chspsb_reg <= mul30(chsp_reg, bsin_reg);
        chspcb_reg <= mul30(chsp_reg, bcos_reg);
        chcb2_reg  <= chcb_reg;
        chsb2_reg  <= chsb_reg;
        shcp2_reg  <= shcp_reg;
        sbcp2_reg  <= sbcp_reg;
        cbcp2_reg  <= cbcp_reg;
        shcb2_reg  <= shcb_reg;
        sbsh2_reg  <= sbsh_reg;
        chcp2_reg  <= chcp_reg;
        sp2_reg    <= sp1_reg;

        m_reg[0] <= MW'(chcb2_reg) + MW'(shspsb_reg);
        m_reg[1] <= MW'(shspcb_reg) - MW'(chsb2_reg);
        m_reg[2] <= MW'(shcp2_reg);
        m_reg[3] <= MW'(sbcp2_reg);
        m_reg[4] <= MW'(cbcp2_reg);
        m_reg[5] <= -MW'(sp2_reg);
        m_reg[6] <= MW'(chspsb_reg) - MW'(shcb2_reg);
        m_reg[7] <= MW'(sbsh2_reg) + MW'(chspcb_reg);
        m_reg[8] <= MW'(chcp2_reg);

        for (int k = 0; k < 9; k++)
            entry_reg[k] <= entry_next[k];
    end

    // transpose for object-to-world
    always_comb
    begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                if (act_reg[MERGE_LAT-2])
                    entry_next[r*3+c] = to_entry(m_reg[c*3+r]);
                else
                    entry_next[r*3+c] = to_entry(m_reg[r*3+c]);
            end
        end
    end

    assign done  = vld_reg[MERGE_LAT-1];
    assign entry = entry_reg;

    a_valid_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid |-> ##MERGE_LAT done)
        else $error("merge dropped a transaction");

    a_done_has_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(in_valid, MERGE_LAT))
        else $error("merge produced a result with no transaction behind it");

    a_done_known: assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown(done))
        else $error("merge strobe is unknown");

endmodule

// ----- design/euler_to_rotation_matrix_core.sv -----
// top level: three trig lanes (heading, pitch, bank) feeding the matrix merge stage
//
// channel   direction  handshake         payload
// command   in         start / busy      action, angle_about_y, angle_about_x, angle_about_z
// result    out        done (strobe)     row1_col1 .. row3_col3
//
// one transaction per cycle; busy is always low
// from the accepting edge to the edge that takes the result, a transaction passes six lane
// stages around the cordic pipeline, one cordic stage per iteration and four merge stages;
// done is high while the result leaves the last merge stage
// results appear for one cycle only and cannot be stalled
// reset clears only the valid pipeline; data registers carry no reset
module euler_to_rotation_matrix_core
    import e2rm_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         action,
    input  logic signed [ANGLE_BITS-1:0] angle_about_y,
    input  logic signed [ANGLE_BITS-1:0] angle_about_x,
    input  logic signed [ANGLE_BITS-1:0] angle_about_z,
    output logic                         done,
    output entry_t                       row1_col1,
    output entry_t                       row1_col2,
    output entry_t                       row1_col3,
    output entry_t                       row2_col1,
    output entry_t                       row2_col2,
    output entry_t                       row2_col3,
    output entry_t                       row3_col1,
    output entry_t                       row3_col2,
    output entry_t                       row3_col3
);

    logic [LANE_LAT-1:0] vld_reg;
    logic [LANE_LAT-1:0] act_reg;

    trig_t  head, pitch, bank;
    entry_t entry [9];

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[LANE_LAT-2:0], start};
    end

    always_ff @(posedge clk)
    begin
        act_reg <= {act_reg[LANE_LAT-2:0], action};
    end

    e2rm_lane u_lane_head (
        .clk   (clk),
        .angle (angle_about_y),
        .trig  (head)
    );

    e2rm_lane u_lane_pitch (
        .clk   (clk),
        .angle (angle_about_x),
        .trig  (pitch)
    );

    e2rm_lane u_lane_bank (
        .clk   (clk),
        .angle (angle_about_z),
        .trig  (bank)
    );

    e2rm_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vld_reg[LANE_LAT-1]),
        .in_action (act_reg[LANE_LAT-1]),
        .head      (head),
        .pitch     (pitch),
        .bank      (bank),
        .done      (done),
        .entry     (entry)
    );

    assign row1_col1 = entry[0];
    assign row1_col2 = entry[1];
    assign row1_col3 = entry[2];
    assign row2_col1 = entry[3];
    assign row2_col2 = entry[4];
    assign row2_col3 = entry[5];
    assign row3_col1 = entry[6];
    assign row3_col2 = entry[7];
    assign row3_col3 = entry[8];

    a_start_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##(LANE_LAT + MERGE_LAT) done)
        else $error("transaction did not come out after the pipeline latency");

    a_done_has_command: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LANE_LAT + MERGE_LAT))
        else $error("result with no command behind it");

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("busy raised on a fully pipelined core");

endmodule

// ----- tb/tb.sv -----
// self-checking testbench for the euler angle to rotation matrix core
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import e2rm_pkg::*;

    typedef struct {
        entry_t e[9];
    } matrix_t;

    class matrix_scoreboard;
        matrix_t pending[$];
        int errors;
        longint atan_tab[CORDIC_STAGES];
        longint x_start;

        function new();
            logic [63:0] s, term, p, r, cand;
            errors = 0;
            atan_tab[0] = 64'd3373259426;
            for (int i = 1; i < CORDIC_STAGES; i++)
            begin
                s = 0;
                for (int k = 0; i * (2 * k + 1) <= 60; k++)
                begin
                    term = (64'd1 << (60 - i * (2 * k + 1))) / 64'(2 * k + 1);
                    if (k % 2 == 0)
                        s = s + term;
                    else
                        s = s - term;
                end
                atan_tab[i] = (s + (64'd1 << 27)) >> 28;
            end
            p = 64'd1 << 60;
            for (int i = 0; i < CORDIC_STAGES; i++)
                p = p + (p >> (2 * i));
            r = 0;
            for (int b = 31; b >= 0; b--)
            begin
                cand = r | (64'd1 << b);
                if (cand * cand <= p)
                    r = cand;
            end
            x_start = (64'd1 << 60) / r;
        endfunction

        function void sin_cos(input logic signed [ANGLE_BITS-1:0] ang,
                              output longint sn, output longint cs);
            longint a, mag, x, y, z, dx, dy;
            bit neg;
            a = ang;
            neg = 0;
            a = a % FULL_TURN;
            if (a < 0)
                a = a + FULL_TURN;
            if (a > 3 * QUARTER_TURN)
                a = a - FULL_TURN;
            else if (a > QUARTER_TURN)
            begin
                a = a - HALF_TURN;
                neg = 1;
            end
            mag = (a < 0) ? -a : a;
            z = (mag * 64'sd13493037705 + HALF_TURN / 2) / HALF_TURN;
            if (a < 0)
                z = -z;
            x = x_start;
            y = 0;
            for (int i = 0; i < CORDIC_STAGES; i++)
            begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0)
                begin
                    x = x - dx;
                    y = y + dy;
                    z = z - atan_tab[i];
                end
                else
                begin
                    x = x + dx;
                    y = y - dy;
                    z = z + atan_tab[i];
                end
            end
            sn = neg ? -y : y;
            cs = neg ? -x : x;
        endfunction

        function longint qmul(input longint a, input longint b);
            return (a * b + (64'sd1 <<< 29)) >>> 30;
        endfunction

        function entry_t round_sat(input longint v);
            longint t;
            t = (v + (64'sd1 <<< (29 - ENTRY_FRAC_BITS))) >>> (30 - ENTRY_FRAC_BITS);
            if (t > (64'sd1 <<< ENTRY_FRAC_BITS) - 1)
                t = (64'sd1 <<< ENTRY_FRAC_BITS) - 1;
            if (t < -(64'sd1 <<< ENTRY_FRAC_BITS))
                t = -(64'sd1 <<< ENTRY_FRAC_BITS);
            return entry_t'(t);
        endfunction

        function void note_command(input logic act, input logic signed [ANGLE_BITS-1:0] hy,
                                   input logic signed [ANGLE_BITS-1:0] px,
                                   input logic signed [ANGLE_BITS-1:0] bz);
            longint sh, ch, sp, cp, sb, cb;
            longint m[9];
            matrix_t res;
            sin_cos(hy, sh, ch);
            sin_cos(px, sp, cp);
            sin_cos(bz, sb, cb);
            m[0] = qmul(ch, cb) + qmul(qmul(sh, sp), sb);
            m[1] = -qmul(ch, sb) + qmul(qmul(sh, sp), cb);
            m[2] = qmul(sh, cp);
            m[3] = qmul(sb, cp);
            m[4] = qmul(cb, cp);
            m[5] = -sp;
            m[6] = -qmul(sh, cb) + qmul(qmul(ch, sp), sb);
            m[7] = qmul(sb, sh) + qmul(qmul(ch, sp), cb);
            m[8] = qmul(ch, cp);
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++)
                    res.e[r * 3 + c] = round_sat(act ? m[c * 3 + r] : m[r * 3 + c]);
            pending.push_back(res);
        endfunction

        function void check_matrix(input matrix_t got);
            matrix_t exp_m;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result transaction", $realtime);
                errors++;
                return;
            end
            exp_m = pending.pop_front();
            for (int i = 0; i < 9; i++)
                if (got.e[i] !== exp_m.e[i])
                begin
                    $display("%0t: row%0d_col%0d expected %0d actual %0d", $realtime,
                             i / 3 + 1, i % 3 + 1, exp_m.e[i], got.e[i]);
                    errors++;
                end
        endfunction
    endclass

    localparam int STALL_LIMIT = 20000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic action = 1'b0;
    logic signed [ANGLE_BITS-1:0] angle_about_y = '0;
    logic signed [ANGLE_BITS-1:0] angle_about_x = '0;
    logic signed [ANGLE_BITS-1:0] angle_about_z = '0;
    logic busy, done;
    entry_t row1_col1, row1_col2, row1_col3, row2_col1, row2_col2, row2_col3;
    entry_t row3_col1, row3_col2, row3_col3;

    matrix_scoreboard sb = new();
    int quiet_cycles = 0;
    bit no_gaps = 0;

    euler_to_rotation_matrix_core u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .action(action),
        .angle_about_y(angle_about_y), .angle_about_x(angle_about_x),
        .angle_about_z(angle_about_z), .done(done),
        .row1_col1(row1_col1), .row1_col2(row1_col2), .row1_col3(row1_col3),
        .row2_col1(row2_col1), .row2_col2(row2_col2), .row2_col3(row2_col3),
        .row3_col1(row3_col1), .row3_col2(row3_col2), .row3_col3(row3_col3)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        matrix_t got;
        bit active;
        active = 1'b0;
        if (rst_n && start && !busy)
        begin
            sb.note_command(action, angle_about_y, angle_about_x, angle_about_z);
            active = 1'b1;
        end
        if (rst_n && done)
        begin
            got.e = '{row1_col1, row1_col2, row1_col3, row2_col1, row2_col2, row2_col3,
                      row3_col1, row3_col2, row3_col3};
            sb.check_matrix(got);
            active = 1'b1;
        end
        if (active)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > STALL_LIMIT)
        begin
            $display("euler_to_rotation_matrix_core regression: fail");
            $finish;
        end
    end

    // called at a rising edge; returns at the edge that accepts the transaction
    task automatic send_angles(input logic act, input int hy, input int px, input int bz);
        int gap;
        gap = 0;
        while (!no_gaps && $urandom_range(99) < 33)
            gap++;
        repeat (gap)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        action <= act;
        angle_about_y <= hy[ANGLE_BITS-1:0];
        angle_about_x <= px[ANGLE_BITS-1:0];
        angle_about_z <= bz[ANGLE_BITS-1:0];
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    function automatic int pick_angle();
        case ($urandom_range(3))
            0: return int'($urandom) % 131072 - (($urandom_range(1) == 1) ? 131072 : 0);
            1: return $urandom_range(46080) - 23040;
            2: return QUARTER_TURN * $urandom_range(8) - 2 * FULL_TURN
                      + $urandom_range(2) - 1;
            default: return $urandom_range(200) - 100;
        endcase
    endfunction

    initial
    begin
        int edge_vals[14];
        edge_vals = '{-131072, 131071, 0, 5760, 5761, 5759, 17280, 17281, 11520,
                      -5760, -11520, 23040, -23040, 1};
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int i = 0; i < 14; i++)
            send_angles(1'(i % 2), edge_vals[i], edge_vals[(i + 5) % 14],
                        edge_vals[(i + 9) % 14]);
        send_angles(1'b0, 1440, -2880, 4000);
        send_angles(1'b1, 1440, -2880, 4000);
        send_angles(1'b1, -131072, -131072, -131072);
        send_angles(1'b0, 131071, 131071, 131071);
        for (int n = 0; n < 800; n++)
        begin
            no_gaps = (n >= 300 && n < 450);
            send_angles(1'($urandom_range(1)), pick_angle(), pick_angle(), pick_angle());
        end
        start <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (sb.errors == 0)
            $display("euler_to_rotation_matrix_core regression: pass");
        else
            $display("euler_to_rotation_matrix_core regression: fail");
        $finish;
    end
endmodule

// ----- sim.f -----
design/e2rm_pkg.sv
design/e2rm_lane.sv
design/e2rm_merge.sv
design/euler_to_rotation_matrix_core.sv
tb/tb.sv
